// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stbs_pkg.sv =====
`timescale 1ns / 1ps

package stbs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 32;

    // action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic write;
        logic emit;
        logic emit_hit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic len_zero;
        logic hit;
        logic next_empty;
    } t_dp_status;

endpackage

// ===== src/sorted_table_binary_search.sv =====
// Binary search over a table of up to 1024 signed 32-bit entries. An item is taken
// when start is high and busy is low. A write item (action 0) stores item_value at
// entry_index and gives no result, so writes may follow every cycle while busy is
// low. A search item (action 1) probes the range [0, table_length) with one table
// read per cycle: busy stays high while it probes, and the result appears on
// o_valid, o_found and o_position in the cycle after the last probe, held for that
// cycle only; the receiver cannot stall it. A search with table_length 0 answers in
// the cycle after it is taken. The pace is set by the single read port of the table
// memory, whose registered read feeds the compare that picks the next probe. The
// length register is written over the cfg channel, which is always ready, and
// should be written only while no search runs.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_action,
    input  logic [ADDR_W-1:0]       i_entry_index,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LEN_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [ADDR_W-1:0]       o_position
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       cfg_we;
    logic       search_beat;
    logic       write_beat;
    logic       miss_beat;

    // config beat
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    stbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_item_value  (i_item_value),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    // beats watched by the checks
    assign search_beat = start && !busy && (i_action == ACT_SEARCH) && !status.len_zero;
    assign write_beat  = start && !busy && (i_action == ACT_WRITE);
    assign miss_beat   = o_valid && !o_found;

    // a search over a non-empty table keeps the block busy
    `ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, search_beat, busy, "search did not probe")

    // a write never produces a result
    `ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, write_beat, !o_valid, "write produced a result")

    // a miss reports position zero
    `ASSERT_SAME(a_miss_pos, i_clk, i_rst_n, miss_beat, o_position == '0, "nonzero miss position")

endmodule

// ===== src/stbs_ctrl.sv =====
`timescale 1ns / 1ps

module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_action,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_action == ACT_SEARCH) && !i_status.len_zero) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_status.hit || i_status.next_empty) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        busy  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_action == ACT_WRITE)) begin
                    o_cmd.write = 1'b1;
                end
                if (start && (i_action == ACT_SEARCH)) begin
                    o_cmd.load = 1'b1;
                    // empty table answers at once
                    o_cmd.emit = i_status.len_zero;
                end
            end
            ST_PROBE: begin
                busy           = 1'b1;
                o_cmd.step     = 1'b1;
                o_cmd.emit     = i_status.hit || i_status.next_empty;
                o_cmd.emit_hit = i_status.hit;
            end
        endcase
    end

endmodule

// ===== src/stbs_dp.sv =====
`timescale 1ns / 1ps

module stbs_dp
    import stbs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic                    i_cfg_we,
    input  logic [LEN_W-1:0]        i_cfg_data,
    input  logic [ADDR_W-1:0]       i_entry_index,
    input  logic signed [VAL_W-1:0] i_item_value,
    output t_dp_status              o_status,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [ADDR_W-1:0]       o_position
);

    logic [VAL_W-1:0]        r_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] r_rdata;
    logic signed [VAL_W-1:0] r_key;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        r_left;
    logic [LEN_W-1:0]        r_right;
    logic [ADDR_W-1:0]       r_mid;
    logic                    r_valid;
    logic                    r_found;
    logic [ADDR_W-1:0]       r_pos;

    logic [LEN_W-1:0]        len_sat;
    logic                    probe_lt;
    logic [LEN_W-1:0]        n_left;
    logic [LEN_W-1:0]        n_right;
    logic [LEN_W-1:0]        n_span;
    logic [LEN_W-1:0]        n_mid;
    logic [ADDR_W-1:0]       rd_addr;

    // length register, saturated at the table depth when used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    assign len_sat = (r_len > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : r_len;

    // halve the range around the probed entry
    always_comb begin
        probe_lt = r_rdata < r_key;
        n_left   = probe_lt ? (LEN_W'(r_mid) + LEN_W'(1)) : r_left;
        n_right  = probe_lt ? r_right : LEN_W'(r_mid);
        n_span   = n_right - n_left;
        n_mid    = n_left + (n_span >> 1);
        rd_addr  = i_cmd.load ? len_sat[LEN_W-1:1] : n_mid[ADDR_W-1:0];
    end

    assign o_status.len_zero   = (len_sat == '0);
    assign o_status.hit        = (r_rdata == r_key);
    assign o_status.next_empty = !(n_left < n_right);

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (LEN_W'(i_entry_index) < LEN_W'(TABLE_DEPTH))) begin
            r_mem[i_entry_index] <= i_item_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // search range and key
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_item_value;
            r_left  <= '0;
            r_right <= len_sat;
            r_mid   <= len_sat[LEN_W-1:1];
        end else if (i_cmd.step) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_mid   <= n_mid[ADDR_W-1:0];
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_found <= i_cmd.emit_hit;
            r_pos   <= i_cmd.emit_hit ? r_mid : '0;
        end
    end

    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule
